@@ src/hsv_to_rgb_top_assert.svh @@
// Assertion macros for the HSV to RGB converter.
// Used by hsv_to_rgb_top; expects a clock named clk and a reset named rst in scope.
`ifndef HSV_TO_RGB_TOP_ASSERT_SVH
`define HSV_TO_RGB_TOP_ASSERT_SVH

// Checks a condition in the same cycle as its trigger.
`define HSV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks a condition in the cycle after its trigger.
`define HSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/hsv_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
// No dependencies; used by every module of the block.
package hsv_pkg;

  localparam int HUE_BITS_DEF     = 16;
  localparam int CHANNEL_BITS_DEF = 8;

  // Hue sector, one sixth of a turn each, named by the colors it runs between.
  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW     = 3'd0,
    SECTOR_YELLOW_GREEN   = 3'd1,
    SECTOR_GREEN_CYAN     = 3'd2,
    SECTOR_CYAN_BLUE      = 3'd3,
    SECTOR_BLUE_MAGENTA   = 3'd4,
    SECTOR_MAGENTA_RED    = 3'd5
  } sector_t;

endpackage

@@ src/hsv_sector_stage.sv @@
// First pipeline stage: splits hue*6 into sector and fraction.
// Depends on hsv_pkg.
module hsv_sector_stage #(
  parameter int HUE_BITS     = hsv_pkg::HUE_BITS_DEF,
  parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic [HUE_BITS-1:0]     hue,
  input  logic [CHANNEL_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS-1:0] brightness,
  output logic                    valid,
  output hsv_pkg::sector_t        sector,
  output logic [HUE_BITS-1:0]     frac,
  output logic [CHANNEL_BITS-1:0] sat,
  output logic [CHANNEL_BITS-1:0] bri
);

  logic [HUE_BITS+2:0] hue_ext;
  logic [HUE_BITS+2:0] hue6;

  // hue * 6 as two shifted adds.
  assign hue_ext = (HUE_BITS+3)'(hue);
  assign hue6    = (hue_ext << 2) + (hue_ext << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      sector <= hsv_pkg::sector_t'(hue6[HUE_BITS+2:HUE_BITS]);
      frac   <= hue6[HUE_BITS-1:0];
      sat    <= saturation;
      bri    <= brightness;
    end
  end

endmodule

@@ src/hsv_fraction_stage.sv @@
// Second pipeline stage: scales saturation by the sector fraction for q and t.
// Depends on hsv_pkg.
module hsv_fraction_stage #(
  parameter int HUE_BITS     = hsv_pkg::HUE_BITS_DEF,
  parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  hsv_pkg::sector_t        in_sector,
  input  logic [HUE_BITS-1:0]     frac,
  input  logic [CHANNEL_BITS-1:0] in_sat,
  input  logic [CHANNEL_BITS-1:0] in_bri,
  output logic                    valid,
  output hsv_pkg::sector_t        sector,
  output logic [CHANNEL_BITS-1:0] k_q,
  output logic [CHANNEL_BITS-1:0] k_t,
  output logic [CHANNEL_BITS-1:0] sat,
  output logic [CHANNEL_BITS-1:0] bri
);

  logic [HUE_BITS+CHANNEL_BITS-1:0] fs_prod;
  logic [CHANNEL_BITS-1:0]          kq_next;
  logic                             rem_nonzero;
  logic [CHANNEL_BITS-1:0]          kt_next;

  // (one - frac) * s >> HUE_BITS equals s minus the ceiling of frac * s >> HUE_BITS,
  // so one product serves both q and t.
  assign fs_prod     = (HUE_BITS+CHANNEL_BITS)'(frac) * (HUE_BITS+CHANNEL_BITS)'(in_sat);
  assign kq_next     = fs_prod[HUE_BITS+CHANNEL_BITS-1:HUE_BITS];
  assign rem_nonzero = |fs_prod[HUE_BITS-1:0];
  assign kt_next     = in_sat - kq_next - CHANNEL_BITS'(rem_nonzero);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      sector <= in_sector;
      k_q    <= kq_next;
      k_t    <= kt_next;
      sat    <= in_sat;
      bri    <= in_bri;
    end
  end

endmodule

@@ src/hsv_product_stage.sv @@
// Third pipeline stage: multiplies value by (full scale - k) for p, q and t.
// Depends on hsv_pkg.
module hsv_product_stage #(
  parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      in_valid,
  input  hsv_pkg::sector_t          in_sector,
  input  logic [CHANNEL_BITS-1:0]   k_q,
  input  logic [CHANNEL_BITS-1:0]   k_t,
  input  logic [CHANNEL_BITS-1:0]   in_sat,
  input  logic [CHANNEL_BITS-1:0]   in_bri,
  output logic                      valid,
  output hsv_pkg::sector_t          sector,
  output logic [2*CHANNEL_BITS-1:0] prod_p,
  output logic [2*CHANNEL_BITS-1:0] prod_q,
  output logic [2*CHANNEL_BITS-1:0] prod_t,
  output logic [CHANNEL_BITS-1:0]   bri
);

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

  logic [2*CHANNEL_BITS-1:0] bri_ext;

  assign bri_ext = (2*CHANNEL_BITS)'(in_bri);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      sector <= in_sector;
      prod_p <= bri_ext * (2*CHANNEL_BITS)'(CH_MAX - in_sat);
      prod_q <= bri_ext * (2*CHANNEL_BITS)'(CH_MAX - k_q);
      prod_t <= bri_ext * (2*CHANNEL_BITS)'(CH_MAX - k_t);
      bri    <= in_bri;
    end
  end

endmodule

@@ src/hsv_output_stage.sv @@
// Last pipeline stage: divides the products by full scale and routes them by sector.
// Depends on hsv_pkg; its registers are the output register of the block.
module hsv_output_stage #(
  parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      in_valid,
  input  hsv_pkg::sector_t          in_sector,
  input  logic [2*CHANNEL_BITS-1:0] prod_p,
  input  logic [2*CHANNEL_BITS-1:0] prod_q,
  input  logic [2*CHANNEL_BITS-1:0] prod_t,
  input  logic [CHANNEL_BITS-1:0]   in_bri,
  output logic                      valid,
  output logic [CHANNEL_BITS-1:0]   red,
  output logic [CHANNEL_BITS-1:0]   green,
  output logic [CHANNEL_BITS-1:0]   blue
);

  // Exact floor(x / (2^n - 1)) for x < (2^n - 1) * 2^n: (x + (x >> n) + 1) >> n.
  function automatic logic [CHANNEL_BITS-1:0] div_full(input logic [2*CHANNEL_BITS-1:0] x);
    logic [2*CHANNEL_BITS:0] acc;
    acc = (2*CHANNEL_BITS+1)'(x) + (2*CHANNEL_BITS+1)'(x >> CHANNEL_BITS)
        + (2*CHANNEL_BITS+1)'(1);
    return acc[2*CHANNEL_BITS-1:CHANNEL_BITS];
  endfunction

  logic [CHANNEL_BITS-1:0] p_val;
  logic [CHANNEL_BITS-1:0] q_val;
  logic [CHANNEL_BITS-1:0] t_val;
  logic [CHANNEL_BITS-1:0] red_next;
  logic [CHANNEL_BITS-1:0] green_next;
  logic [CHANNEL_BITS-1:0] blue_next;

  assign p_val = div_full(prod_p);
  assign q_val = div_full(prod_q);
  assign t_val = div_full(prod_t);

  always_comb begin
    unique case (in_sector)
      hsv_pkg::SECTOR_RED_YELLOW: begin
        red_next = in_bri; green_next = t_val;  blue_next = p_val;
      end
      hsv_pkg::SECTOR_YELLOW_GREEN: begin
        red_next = q_val;  green_next = in_bri; blue_next = p_val;
      end
      hsv_pkg::SECTOR_GREEN_CYAN: begin
        red_next = p_val;  green_next = in_bri; blue_next = t_val;
      end
      hsv_pkg::SECTOR_CYAN_BLUE: begin
        red_next = p_val;  green_next = q_val;  blue_next = in_bri;
      end
      hsv_pkg::SECTOR_BLUE_MAGENTA: begin
        red_next = t_val;  green_next = p_val;  blue_next = in_bri;
      end
      default: begin
        red_next = in_bri; green_next = p_val;  blue_next = q_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

@@ src/hsv_to_rgb_top.sv @@
// Top level of the HSV to RGB pixel converter: four-stage pipeline with stream ports.
// Depends on hsv_pkg, the four hsv_*_stage modules and hsv_to_rgb_top_assert.svh.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------------
//   s_*     | in        | s_tvalid, s_tready | s_tdata: hue, saturation, brightness
//   m_*     | out       | m_tvalid, m_tready | m_tdata: red, green, blue
//
// One pixel can enter on every clock while the output side is not stalled. A converted
// pixel leaves once it has passed through the four register stages: sector split,
// fraction multiply, value multiply, and divide plus channel select.
// Reset (rst, synchronous, active high) clears only the stage valid bits.
// A stall on m_tready holds the output stage; earlier stages keep moving while there is an
// empty slot ahead of them, so bubbles are squeezed out and no pixel is lost or repeated.
`include "hsv_to_rgb_top_assert.svh"

module hsv_to_rgb_top #(
  parameter int HUE_BITS     = hsv_pkg::HUE_BITS_DEF,
  parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF,
  localparam int IN_BITS     = HUE_BITS + 2*CHANNEL_BITS,
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = 3*CHANNEL_BITS,
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0 up: hue, saturation, brightness, then zero padding.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0 up: red, green, blue, then zero padding.
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // Unpack the input transfer.
  logic [HUE_BITS-1:0]     in_hue;
  logic [CHANNEL_BITS-1:0] in_sat;
  logic [CHANNEL_BITS-1:0] in_bri;

  assign in_hue = s_tdata[HUE_BITS-1:0];
  assign in_sat = s_tdata[HUE_BITS+CHANNEL_BITS-1:HUE_BITS];
  assign in_bri = s_tdata[HUE_BITS+2*CHANNEL_BITS-1:HUE_BITS+CHANNEL_BITS];

  // Each stage loads when it is empty or when the stage after it is moving on.
  logic adv1;
  logic adv2;
  logic adv3;
  logic adv4;

  logic v1;
  logic v2;
  logic v3;
  logic v4;

  assign adv4 = !v4 || m_tready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign s_tready = adv1;

  // Stage 1 outputs.
  hsv_pkg::sector_t        sector1;
  logic [HUE_BITS-1:0]     frac1;
  logic [CHANNEL_BITS-1:0] sat1;
  logic [CHANNEL_BITS-1:0] bri1;

  // Stage 2 outputs.
  hsv_pkg::sector_t        sector2;
  logic [CHANNEL_BITS-1:0] kq2;
  logic [CHANNEL_BITS-1:0] kt2;
  logic [CHANNEL_BITS-1:0] sat2;
  logic [CHANNEL_BITS-1:0] bri2;

  // Stage 3 outputs.
  hsv_pkg::sector_t          sector3;
  logic [2*CHANNEL_BITS-1:0] prod_p3;
  logic [2*CHANNEL_BITS-1:0] prod_q3;
  logic [2*CHANNEL_BITS-1:0] prod_t3;
  logic [CHANNEL_BITS-1:0]   bri3;

  // Stage 4 outputs, which form the output register.
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  hsv_sector_stage #(
    .HUE_BITS     (HUE_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_sector (
    .clk        (clk),
    .rst        (rst),
    .advance    (adv1),
    .in_valid   (s_tvalid),
    .hue        (in_hue),
    .saturation (in_sat),
    .brightness (in_bri),
    .valid      (v1),
    .sector     (sector1),
    .frac       (frac1),
    .sat        (sat1),
    .bri        (bri1)
  );

  hsv_fraction_stage #(
    .HUE_BITS     (HUE_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_fraction (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv2),
    .in_valid  (v1),
    .in_sector (sector1),
    .frac      (frac1),
    .in_sat    (sat1),
    .in_bri    (bri1),
    .valid     (v2),
    .sector    (sector2),
    .k_q       (kq2),
    .k_t       (kt2),
    .sat       (sat2),
    .bri       (bri2)
  );

  hsv_product_stage #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_product (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv3),
    .in_valid  (v2),
    .in_sector (sector2),
    .k_q       (kq2),
    .k_t       (kt2),
    .in_sat    (sat2),
    .in_bri    (bri2),
    .valid     (v3),
    .sector    (sector3),
    .prod_p    (prod_p3),
    .prod_q    (prod_q3),
    .prod_t    (prod_t3),
    .bri       (bri3)
  );

  hsv_output_stage #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_output (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv4),
    .in_valid  (v3),
    .in_sector (sector3),
    .prod_p    (prod_p3),
    .prod_q    (prod_q3),
    .prod_t    (prod_t3),
    .in_bri    (bri3),
    .valid     (v4),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign m_tvalid = v4;
  assign m_tdata  = OUT_DATA_W'({blue, green, red});

  // An empty output stage lets every earlier stage move, so the input must be open.
  `HSV_ASSERT_SAME(a_ready_when_drained, !v4, s_tready, "input closed while the output stage is empty")
  // The q and t weights together never exceed the saturation they were split from.
  `HSV_ASSERT_SAME(a_weights_bounded, v2, ({1'b0, kq2} + {1'b0, kt2}) <= {1'b0, sat2}, "q and t weights exceed saturation")
  // A product stage that is blocked keeps its pixel and its products.
  `HSV_ASSERT_NEXT(a_products_held, v3 && !adv4, v3 && $stable(prod_p3) && $stable(prod_q3) && $stable(prod_t3), "stalled product stage changed")

endmodule

@@ test/hsv_to_rgb_top_tb.sv @@
// Self-checking testbench for hsv_to_rgb_top, the streaming HSV to RGB pixel converter.
// Depends on hsv_pkg and the hsv_to_rgb_top RTL.
// Pixels go in over s_*, expected colors are predicted here, and every m_* transfer is checked.
`timescale 1ns / 1ps

module hsv_to_rgb_top_tb;

  localparam int HUE_BITS   = hsv_pkg::HUE_BITS_DEF;
  localparam int CH_BITS    = hsv_pkg::CHANNEL_BITS_DEF;
  localparam int IN_W       = ((HUE_BITS + 2*CH_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((3*CH_BITS + 7) / 8) * 8;
  localparam logic [63:0] HUE_ONE = 64'd1 << HUE_BITS;
  localparam logic [63:0] CH_MAX  = (64'd1 << CH_BITS) - 64'd1;
  localparam int STALL_LIMIT = 5000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
  } rgb_t;

  // Holds the colors still owed by the converter, in transfer order, and compares
  // each output transfer against the oldest of them.
  class color_checker;
    rgb_t pending_rgb[$];
    int   mismatches;
    int   checked;
    int   sector_hits[6];

    function new();
      mismatches = 0;
      checked = 0;
      foreach (sector_hits[i]) sector_hits[i] = 0;
    endfunction

    // v * (M - k) / M with truncation.
    function logic [CH_BITS-1:0] dim(logic [63:0] v, logic [63:0] k);
      return CH_BITS'((v * (CH_MAX - k)) / CH_MAX);
    endfunction

    function rgb_t hsv_convert(logic [IN_W-1:0] pixel);
      logic [63:0] hue, sat, val, h6, frac;
      logic [CH_BITS-1:0] p, q, t, v;
      hsv_pkg::sector_t sec;
      rgb_t c;
      hue  = 64'(pixel[HUE_BITS-1:0]);
      sat  = 64'(pixel[HUE_BITS +: CH_BITS]);
      val  = 64'(pixel[HUE_BITS+CH_BITS +: CH_BITS]);
      h6   = hue * 64'd6;
      sec  = hsv_pkg::sector_t'(3'(h6 >> HUE_BITS));
      frac = h6 & (HUE_ONE - 64'd1);
      v    = CH_BITS'(val);
      p    = dim(val, sat);
      q    = dim(val, (frac * sat) >> HUE_BITS);
      t    = dim(val, ((HUE_ONE - frac) * sat) >> HUE_BITS);
      sector_hits[int'(sec)]++;
      case (sec)
        hsv_pkg::SECTOR_RED_YELLOW:   c = '{red: v, green: t, blue: p};
        hsv_pkg::SECTOR_YELLOW_GREEN: c = '{red: q, green: v, blue: p};
        hsv_pkg::SECTOR_GREEN_CYAN:   c = '{red: p, green: v, blue: t};
        hsv_pkg::SECTOR_CYAN_BLUE:    c = '{red: p, green: q, blue: v};
        hsv_pkg::SECTOR_BLUE_MAGENTA: c = '{red: t, green: p, blue: v};
        default:                      c = '{red: v, green: p, blue: q};
      endcase
      return c;
    endfunction

    function void note_pixel(logic [IN_W-1:0] pixel);
      pending_rgb.push_back(hsv_convert(pixel));
    endfunction

    function void check_pixel(logic [OUT_W-1:0] data);
      rgb_t got, want;
      got = rgb_t'(data[3*CH_BITS-1:0]);
      checked++;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected output transfer r=%0d g=%0d b=%0d",
                   $realtime, got.red, got.green, got.blue);
        return;
      end
      want = pending_rgb.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: color mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   $realtime, want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction

    function int pending();
      return pending_rgb.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  color_checker board;
  int tx_idle_pct = 10;
  int rx_idle_pct = 10;
  int rx_hold_cycles = 0;
  int pixels_in = 0;
  int quiet_cycles = 0;

  hsv_to_rgb_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Output side: mostly ready, with random stalls. When a hold is requested, the
  // receiver keeps m_tready low for the requested hold so the pipeline backs up into s_tready.
  initial begin
    forever begin
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      @(posedge clk);
    end
  end

  // Transfers are observed on the edge where they happen, using the values that were
  // set up before that edge. The same block runs the stall watchdog: it trips when
  // neither side moves data for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.note_pixel(s_tdata);
        pixels_in++;
      end
      if (m_tvalid && m_tready)
        board.check_pixel(m_tdata);
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d colors still owed",
               $realtime, STALL_LIMIT, board.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_pixel(int hue, int sat, int val);
    return {CH_BITS'(val), CH_BITS'(sat), HUE_BITS'(hue)};
  endfunction

  // Mostly fully random pixels; the rest sit on sector edges or at the ends of the
  // saturation and value range, where the truncation is easiest to get wrong.
  function automatic logic [IN_W-1:0] random_pixel();
    int hue, sat, val, k;
    hue = $urandom_range(0, (1 << HUE_BITS) - 1);
    sat = $urandom_range(0, int'(CH_MAX));
    val = $urandom_range(0, int'(CH_MAX));
    case ($urandom_range(0, 9))
      6: begin
        k = $urandom_range(0, 5);
        hue = (k * (1 << HUE_BITS) + 5) / 6 + $urandom_range(0, 4) - 2;
      end
      7: sat = $urandom_range(0, 1) ? int'(CH_MAX) : $urandom_range(0, 1);
      8: val = $urandom_range(0, 1) ? int'(CH_MAX) : $urandom_range(0, 1);
      9: begin
        sat = $urandom_range(0, 1) ? int'(CH_MAX) : 0;
        val = $urandom_range(0, 1) ? int'(CH_MAX) : 0;
      end
      default: ;
    endcase
    return pack_pixel(hue, sat, val);
  endfunction

  // Offers one pixel and returns on the edge where it is taken. An optional one-cycle
  // idle gap comes first; otherwise s_tvalid stays high from the previous transfer.
  task automatic send_pixel(logic [IN_W-1:0] pixel);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pixel;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_colors();
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [IN_W-1:0] directed[$];
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: primaries, both sides of every sector edge but the one at 32768, the two
    // hues with a zero fraction, gray and black, and alternating bit patterns in every field.
    directed = '{
      pack_pixel(0, 255, 255),     pack_pixel(65535, 255, 255),
      pack_pixel(10922, 255, 255), pack_pixel(10923, 255, 255),
      pack_pixel(21845, 255, 255), pack_pixel(21846, 255, 255),
      pack_pixel(32768, 255, 255), pack_pixel(32768, 128, 200),
      pack_pixel(43690, 200, 255), pack_pixel(43691, 200, 255),
      pack_pixel(54613, 255, 180), pack_pixel(54614, 255, 180),
      pack_pixel(5461, 128, 200),  pack_pixel(0, 0, 255),
      pack_pixel(32768, 0, 0),     pack_pixel(16384, 255, 0),
      pack_pixel(49152, 128, 128), pack_pixel(60000, 1, 254),
      pack_pixel(27000, 254, 1),   pack_pixel(16'hAAAA, 8'hAA, 8'h55),
      pack_pixel(16'h5555, 8'h55, 8'hAA)
    };
    foreach (directed[i]) send_pixel(directed[i]);

    // Random pixels with idling on both sides.
    repeat (230) send_pixel(random_pixel());

    // A back-to-back stretch with no idling at all.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (150) send_pixel(random_pixel());

    // The output side holds off for a long time while input keeps coming, so the
    // pipeline fills and s_tready must drop.
    rx_hold_cycles = 80;
    repeat (30) send_pixel(random_pixel());

    // The input side pauses until every owed color has come out.
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    s_tvalid <= 1'b0;
    drain_colors();
    repeat (270) send_pixel(random_pixel());
    s_tvalid <= 1'b0;

    drain_colors();
    repeat (12) @(posedge clk);

    $display("Sent %0d pixels and checked %0d colors; sector counts %0d %0d %0d %0d %0d %0d.",
             pixels_in, board.checked, board.sector_hits[0], board.sector_hits[1],
             board.sector_hits[2], board.sector_hits[3], board.sector_hits[4],
             board.sector_hits[5]);
    $display("Idle gaps on both sides, a back-to-back stretch, a long output stall and a drain.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d colors never delivered", board.mismatches, board.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ hsv_to_rgb_top.f @@
+incdir+src
src/hsv_pkg.sv
src/hsv_sector_stage.sv
src/hsv_fraction_stage.sv
src/hsv_product_stage.sv
src/hsv_output_stage.sv
src/hsv_to_rgb_top.sv
test/hsv_to_rgb_top_tb.sv
